// ----- src/lsb_stego_frame_decoder_defines.svh -----
// assertion macros shared by the lsb stego frame decoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef LSB_STEGO_FRAME_DECODER_DEFINES_SVH
`define LSB_STEGO_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define LSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsd assertion failed");
// clocked check that also holds during reset
`define LSD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lsd assertion failed");
`else
`define LSD_ASSERT(label, clk, rst_n, prop)
`define LSD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- src/lsd_pkg.sv -----
// types and constants of the lsb stego frame decoder
// no dependencies; used by the decoder, queue, front and back rtl files
package lsd_pkg;

    // configuration register indexes
    localparam logic REG_MAGIC_CODE  = 1'b0;
    localparam logic REG_HEADER_SKIP = 1'b1;

    localparam logic [15:0] MAGIC_CODE_RESET  = 16'h0000;
    localparam logic [7:0]  HEADER_SKIP_RESET = 8'd54;

    localparam int unsigned MAX_EXT_LEN_DEFAULT = 8;

    // result kinds
    localparam logic [1:0] KIND_EXT_CHAR   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC  = 2'd2;
    localparam logic [1:0] KIND_EXT_LONG   = 2'd3;

    // decoupling queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified item handed from front to back
    typedef struct packed {
        logic restart;
        logic has_bit;
        logic hidden_bit;
    } bit_entry_t;

    // frame parse phases of the back part
    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b0000001,
        PH_EXTLEN  = 7'b0000010,
        PH_EXTCHR  = 7'b0000100,
        PH_PAYLEN  = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_HALT    = 7'b1000000
    } phase_t;

endpackage

// ----- src/lsd_channels.sv -----
// valid/ready channel interfaces of the lsb stego frame decoder
// depends on nothing; used by the front, back and top level
interface lsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       start_of_file;
    modport source (output valid, pixel_byte, start_of_file, input ready);
    modport sink   (input valid, pixel_byte, start_of_file, output ready);
endinterface

interface lsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [1:0] result_kind;
    logic       last;
    modport source (output valid, value, result_kind, last, input ready);
    modport sink   (input valid, value, result_kind, last, output ready);
endinterface

interface lsd_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/lsb_stego_frame_decoder.sv -----
// lsb stego frame decoder: file bytes one item per cycle at full rate;
// after header_skip leading bytes, bit 0 of each byte is shifted in msb first
// and parsed as magic, extension length, extension chars, payload length and
// payload bytes. the front stage accepts one item every cycle while its
// queue has room, and the back stage retires one queued item per cycle while
// its output register is free, so the sustained rate is one byte per cycle
// while results are taken. a completing byte is registered in the queue and
// then parsed into the output register. the four-entry queue lets bytes be
// taken while a result waits and absorbs short stalls downstream. magic
// mismatch or an over-long extension emits one error item and halts the parse
// until the next start_of_file. the user must write configuration through cfg
// only while the block is idle, which it does not enforce; cfg is always ready.
// depends on lsd_pkg, lsd_channels, lsd_queue, lsd_front and lsd_back
module lsb_stego_frame_decoder #(
    parameter int unsigned MAX_EXT_LEN = lsd_pkg::MAX_EXT_LEN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    lsd_byte_if.sink      bytes,
    lsd_result_if.source  results,
    lsd_cfg_if.sink       cfg
);

    // configuration registers
    logic [15:0] magic_code_reg, magic_code_next;
    logic [7:0]  header_skip_reg, header_skip_next;

    // front to queue
    logic                q_push;
    lsd_pkg::bit_entry_t q_push_data;
    logic                q_full;

    // queue to back
    logic                q_pop;
    lsd_pkg::bit_entry_t q_pop_data;
    logic                q_empty;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        magic_code_next  = magic_code_reg;
        header_skip_next = header_skip_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                lsd_pkg::REG_MAGIC_CODE:  magic_code_next  = cfg.data;
                lsd_pkg::REG_HEADER_SKIP: header_skip_next = cfg.data[7:0];
                default:                  magic_code_next  = magic_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_code_reg  <= lsd_pkg::MAGIC_CODE_RESET;
            header_skip_reg <= lsd_pkg::HEADER_SKIP_RESET;
        end
        else
        begin
            magic_code_reg  <= magic_code_next;
            header_skip_reg <= header_skip_next;
        end
    end

    // header skip and bit classification
    lsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .header_skip (header_skip_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    // decoupling queue
    lsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // frame parser and output register
    lsd_back #(
        .MAX_EXT_LEN (MAX_EXT_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_pop_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .magic_code (magic_code_reg),
        .results    (results)
    );

endmodule

// ----- src/lsd_queue.sv -----
// short fifo of classified items between the front and back parts
// depends on lsd_pkg
module lsd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lsd_pkg::bit_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output lsd_pkg::bit_entry_t pop_data,
    output logic                empty
);

    lsd_pkg::bit_entry_t                mem [lsd_pkg::QUEUE_DEPTH];
    logic [lsd_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [lsd_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [lsd_pkg::QCNT_W-1:0]         count_reg, count_next;

    assign full     = (count_reg == lsd_pkg::QCNT_W'(lsd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lsd_pkg::QPTR_W'(lsd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + lsd_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lsd_pkg::QPTR_W'(lsd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + lsd_pkg::QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + lsd_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - lsd_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/lsd_front.sv -----
// front part: accepts file bytes, skips the header, forwards hidden bits
// depends on lsd_pkg and lsd_channels
module lsd_front (
    input  logic                clk,
    input  logic                rst_n,
    lsd_byte_if.sink            bytes,
    input  logic [7:0]          header_skip,
    input  logic                q_full,
    output logic                q_push,
    output lsd_pkg::bit_entry_t q_data
);

    logic       past_header_reg, past_header_next;
    logic [7:0] header_count_reg, header_count_next;
    logic       accept;
    logic       past_cur;
    logic [7:0] count_cur;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        past_cur          = bytes.start_of_file ? 1'b0 : past_header_reg;
        count_cur         = bytes.start_of_file ? 8'd0 : header_count_reg;
        past_header_next  = past_header_reg;
        header_count_next = header_count_reg;
        q_push            = 1'b0;
        q_data.restart    = bytes.start_of_file;
        q_data.has_bit    = 1'b0;
        q_data.hidden_bit = bytes.pixel_byte[0];
        if (accept)
        begin
            past_header_next  = past_cur;
            header_count_next = count_cur;
            if (!past_cur && (count_cur < header_skip))
            begin
                // header byte: only a restart needs to reach the back part
                header_count_next = count_cur + 8'd1;
                q_push            = bytes.start_of_file;
            end
            else
            begin
                past_header_next = 1'b1;
                q_data.has_bit   = 1'b1;
                q_push           = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            past_header_reg  <= 1'b0;
            header_count_reg <= '0;
        end
        else
        begin
            past_header_reg  <= past_header_next;
            header_count_reg <= header_count_next;
        end
    end

endmodule

// ----- src/lsd_back.sv -----
// back part: gathers hidden bits, parses the frame, holds the result register
// depends on lsd_pkg, lsd_channels and the assertion macro header
`include "lsb_stego_frame_decoder_defines.svh"

module lsd_back #(
    parameter int unsigned MAX_EXT_LEN = lsd_pkg::MAX_EXT_LEN_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsd_pkg::bit_entry_t q_data,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic [15:0]         magic_code,
    lsd_result_if.source        results
);

    lsd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      bit_count_reg, bit_count_next;
    logic [31:0]     shift_reg, shift_next;
    logic [30:0]     remaining_reg, remaining_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      value_reg, value_next;
    logic [1:0]      kind_reg, kind_next;
    logic            last_reg, last_next;

    lsd_pkg::phase_t ph;
    logic [4:0]      cnt;
    logic [31:0]     shf;
    logic [30:0]     rem;
    logic [30:0]     len;
    logic            word_done;
    logic            res_valid;
    logic [7:0]      res_value;
    logic [1:0]      res_kind;
    logic            res_last;

    assign q_pop = !q_empty && (!out_valid_reg || results.ready);

    always_comb
    begin
        ph        = q_data.restart ? lsd_pkg::PH_MAGIC : phase_reg;
        cnt       = q_data.restart ? 5'd0 : bit_count_reg;
        shf       = q_data.restart ? 32'd0 : shift_reg;
        rem       = q_data.restart ? 31'd0 : remaining_reg;
        len       = 31'd0;
        word_done = 1'b0;
        res_valid = 1'b0;
        res_value = 8'd0;
        res_kind  = lsd_pkg::KIND_EXT_CHAR;
        res_last  = 1'b0;

        if (q_data.has_bit && (ph != lsd_pkg::PH_DONE) && (ph != lsd_pkg::PH_HALT))
        begin
            shf = {shf[30:0], q_data.hidden_bit};
            len = shf[31] ? 31'd0 : shf[30:0];
            case (ph)
                lsd_pkg::PH_MAGIC:  word_done = (cnt == 5'd15);
                lsd_pkg::PH_EXTLEN: word_done = (cnt == 5'd31);
                lsd_pkg::PH_PAYLEN: word_done = (cnt == 5'd31);
                default:            word_done = (cnt == 5'd7);
            endcase
            if (!word_done)
            begin
                cnt = cnt + 5'd1;
            end
            else
            begin
                cnt = 5'd0;
                case (ph)
                    lsd_pkg::PH_MAGIC:
                    begin
                        if (shf[15:0] != magic_code)
                        begin
                            ph        = lsd_pkg::PH_HALT;
                            res_valid = 1'b1;
                            res_kind  = lsd_pkg::KIND_BAD_MAGIC;
                            res_last  = 1'b1;
                        end
                        else
                        begin
                            ph = lsd_pkg::PH_EXTLEN;
                        end
                    end
                    lsd_pkg::PH_EXTLEN:
                    begin
                        if (len > 31'(MAX_EXT_LEN))
                        begin
                            ph        = lsd_pkg::PH_HALT;
                            res_valid = 1'b1;
                            res_kind  = lsd_pkg::KIND_EXT_LONG;
                            res_last  = 1'b1;
                        end
                        else
                        begin
                            rem = len;
                            ph  = (len == 31'd0) ? lsd_pkg::PH_PAYLEN : lsd_pkg::PH_EXTCHR;
                        end
                    end
                    lsd_pkg::PH_EXTCHR:
                    begin
                        rem       = rem - 31'd1;
                        ph        = (rem == 31'd0) ? lsd_pkg::PH_PAYLEN : lsd_pkg::PH_EXTCHR;
                        res_valid = 1'b1;
                        res_value = shf[7:0];
                        res_kind  = lsd_pkg::KIND_EXT_CHAR;
                    end
                    lsd_pkg::PH_PAYLEN:
                    begin
                        rem = len;
                        ph  = (len == 31'd0) ? lsd_pkg::PH_DONE : lsd_pkg::PH_PAYLOAD;
                    end
                    default:
                    begin
                        rem       = rem - 31'd1;
                        ph        = (rem == 31'd0) ? lsd_pkg::PH_DONE : lsd_pkg::PH_PAYLOAD;
                        res_valid = 1'b1;
                        res_value = shf[7:0];
                        res_kind  = lsd_pkg::KIND_PAYLOAD;
                        res_last  = (rem == 31'd0);
                    end
                endcase
            end
        end

        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !results.ready;
        value_next     = value_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        if (q_pop)
        begin
            phase_next     = ph;
            bit_count_next = cnt;
            shift_next     = shf;
            remaining_next = rem;
            if (res_valid)
            begin
                out_valid_next = 1'b1;
                value_next     = res_value;
                kind_next      = res_kind;
                last_next      = res_last;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.value       = value_reg;
    assign results.result_kind = kind_reg;
    assign results.last        = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lsd_pkg::PH_MAGIC;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
    end

    // error results always close the stream
    `LSD_ASSERT(a_error_is_last, clk, rst_n,
        (out_valid_reg && (kind_reg == lsd_pkg::KIND_BAD_MAGIC ||
        kind_reg == lsd_pkg::KIND_EXT_LONG)) |-> last_reg)
    // a finished or halted parse never holds a partial word
    `LSD_ASSERT(a_stop_no_partial, clk, rst_n,
        (phase_reg == lsd_pkg::PH_DONE || phase_reg == lsd_pkg::PH_HALT) |->
        (bit_count_reg == 5'd0))
    // extension countdown stays inside its bound
    `LSD_ASSERT(a_ext_bound, clk, rst_n,
        (phase_reg == lsd_pkg::PH_EXTCHR) |->
        (remaining_reg != 31'd0 && remaining_reg <= 31'(MAX_EXT_LEN)))
    // phase may still be unknown before the first reset edge
    `LSD_ASSERT_ALWAYS(a_phase_onehot, clk, !rst_n || $onehot(phase_reg))

endmodule

// ----- tb/tb_lsb_stego_frame_decoder.sv -----
// self-checking testbench for lsb_stego_frame_decoder: streams stego file bytes,
// predicts the decoded frame items and checks every result item in order
// depends on lsd_pkg, lsd_channels and the lsb_stego_frame_decoder rtl
module tb_lsb_stego_frame_decoder;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 3000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 16;     // front, queue and output register drain
    localparam int EXT_BOUND     = lsd_pkg::MAX_EXT_LEN_DEFAULT;
    localparam int PHASE_BYTES   = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int PAYLOAD_CAP   = 40;     // huge lengths are cut off after this many

    typedef enum logic [2:0] {
        ST_HEADER, ST_MAGIC, ST_EXTLEN, ST_EXTCHR, ST_PAYLEN, ST_PAYLOAD, ST_DONE, ST_HALT
    } parse_step_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] kind;
        logic       last;
    } decoded_item_t;

    // frame decoder prediction plus the queue of decoded items still due
    class frame_scoreboard;
        logic [15:0]   magic;
        logic [7:0]    skip;
        parse_step_t   step;
        logic [4:0]    bit_cnt;
        logic [31:0]   shifter;
        logic [7:0]    hdr_cnt;
        logic [31:0]   left;
        decoded_item_t due[$];
        int            fail_count;

        function new();
            magic      = lsd_pkg::MAGIC_CODE_RESET;
            skip       = lsd_pkg::HEADER_SKIP_RESET;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            step    = ST_HEADER;
            bit_cnt = '0;
            shifter = '0;
            hdr_cnt = '0;
            left    = '0;
        endfunction

        task report(string msg);
            fail_count++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void write_reg(logic idx, logic [15:0] data);
            if (idx == lsd_pkg::REG_MAGIC_CODE)
                magic = data;
            else
                skip = data[7:0];
        endfunction

        // a length word with the top bit set counts as zero
        function logic [31:0] eff_len(logic [31:0] w);
            return w[31] ? 32'd0 : w;
        endfunction

        function void push(logic [7:0] v, logic [1:0] k, logic l);
            decoded_item_t d;
            d.value = v;
            d.kind  = k;
            d.last  = l;
            due.push_back(d);
        endfunction

        function void note_byte(logic [7:0] pix, logic sof);
            int unsigned need;
            logic [31:0] len;
            if (sof)
                restart();
            if (step == ST_DONE || step == ST_HALT)
                return;
            if (step == ST_HEADER)
            begin
                if (hdr_cnt < skip)
                begin
                    hdr_cnt++;
                    return;
                end
                step = ST_MAGIC;
            end
            shifter = {shifter[30:0], pix[0]};
            case (step)
                ST_MAGIC:            need = 16;
                ST_EXTLEN, ST_PAYLEN: need = 32;
                default:             need = 8;
            endcase
            if (int'(bit_cnt) + 1 < need)
            begin
                bit_cnt++;
                return;
            end
            bit_cnt = '0;
            case (step)
                ST_MAGIC:
                    if (shifter[15:0] != magic)
                    begin
                        step = ST_HALT;
                        push(8'd0, lsd_pkg::KIND_BAD_MAGIC, 1'b1);
                    end
                    else
                        step = ST_EXTLEN;
                ST_EXTLEN:
                begin
                    len = eff_len(shifter);
                    if (len > EXT_BOUND)
                    begin
                        step = ST_HALT;
                        push(8'd0, lsd_pkg::KIND_EXT_LONG, 1'b1);
                    end
                    else
                    begin
                        left = len;
                        if (len == 0)
                            step = ST_PAYLEN;
                        else
                            step = ST_EXTCHR;
                    end
                end
                ST_EXTCHR:
                begin
                    left--;
                    if (left == 0)
                        step = ST_PAYLEN;
                    push(shifter[7:0], lsd_pkg::KIND_EXT_CHAR, 1'b0);
                end
                ST_PAYLEN:
                begin
                    len  = eff_len(shifter);
                    left = len;
                    if (len == 0)
                        step = ST_DONE;
                    else
                        step = ST_PAYLOAD;
                end
                default:
                begin
                    left--;
                    if (left == 0)
                    begin
                        step = ST_DONE;
                        push(shifter[7:0], lsd_pkg::KIND_PAYLOAD, 1'b1);
                    end
                    else
                        push(shifter[7:0], lsd_pkg::KIND_PAYLOAD, 1'b0);
                end
            endcase
        endfunction

        task check_result(logic [7:0] v, logic [1:0] k, logic l);
            decoded_item_t want;
            if (due.size() == 0)
            begin
                report($sformatf("unexpected item value=%0h kind=%0d last=%0b", v, k, l));
                return;
            end
            want = due.pop_front();
            if (v !== want.value)
                report($sformatf("value %0h, wanted %0h", v, want.value));
            if (k !== want.kind)
                report($sformatf("result_kind %0d, wanted %0d", k, want.kind));
            if (l !== want.last)
                report($sformatf("last %0b, wanted %0b", l, want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsd_byte_if   in_ch ();
    lsd_result_if out_ch ();
    lsd_cfg_if    cfg_ch ();

    lsb_stego_frame_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    frame_scoreboard sb = new();

    // stimulus knobs shared between the driver tasks and the ready process
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          hold_req       = 0;
    int          hold_left      = 0;
    int          sent_bytes     = 0;
    logic        next_sof       = 1'b0;
    logic [15:0] cur_magic      = lsd_pkg::MAGIC_CODE_RESET;
    logic [7:0]  cur_skip       = lsd_pkg::HEADER_SKIP_RESET;

    always #CLK_HALF clk = ~clk;

    // receiver: random stalls per phase, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one monitor for all three channels, so the order of updates is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.pixel_byte, in_ch.start_of_file);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.value, out_ch.result_kind, out_ch.last);
        end
    end

    // watchdog: ends the run when no channel moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic set_idle(input idle_mode_t mode);
        send_gap_pct   = (mode == IDLE_SENDER)   ? 51 : (mode == IDLE_BOTH) ? 13 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 51 : (mode == IDLE_BOTH) ? 13 : 0;
    endtask

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_byte(input logic [7:0] pix, input logic sof);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.pixel_byte    <= pix;
        in_ch.start_of_file <= sof;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_bytes++;
    endtask

    // file byte carrying one hidden bit in bit 0, upper bits random
    task automatic send_file_byte(input logic hb);
        logic [7:0] pix;
        pix    = 8'($urandom);
        pix[0] = hb;
        send_byte(pix, next_sof);
        next_sof = 1'b0;
    endtask

    // wait for every due item, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data byte is junk, only the low byte is the skip count
    task automatic set_skip(input logic [7:0] s);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(lsd_pkg::REG_HEADER_SKIP, {junk, s});
        cur_skip = s;
    endtask

    task automatic set_config(input logic [15:0] m, input logic [7:0] s);
        write_reg(lsd_pkg::REG_MAGIC_CODE, m);
        cur_magic = m;
        set_skip(s);
    endtask

    // one file: header bytes, then magic, lengths and contents as hidden bits;
    // cut >= 0 stops after that many hidden bits (broken frame)
    task automatic send_frame(input logic fresh, input int hdr_n, input logic [15:0] mg,
                              input logic [31:0] ext_w, input logic [31:0] pay_w,
                              input int cut);
        logic        bits[$];
        logic [31:0] ext_len;
        logic [31:0] pay_len;
        logic [7:0]  ch;
        int          i;
        int          j;
        next_sof = fresh;
        repeat (hdr_n) send_file_byte(1'($urandom));
        for (i = 15; i >= 0; i--)
            bits.push_back(mg[i]);
        for (i = 31; i >= 0; i--)
            bits.push_back(ext_w[i]);
        ext_len = ext_w[31] ? 32'd0 : ext_w;
        if (ext_len <= EXT_BOUND)
        begin
            for (i = 0; i < int'(ext_len); i++)
            begin
                ch = 8'($urandom);
                for (j = 7; j >= 0; j--)
                    bits.push_back(ch[j]);
            end
            for (i = 31; i >= 0; i--)
                bits.push_back(pay_w[i]);
            pay_len = pay_w[31] ? 32'd0 : pay_w;
            if (pay_len > PAYLOAD_CAP)
                pay_len = PAYLOAD_CAP;
            for (i = 0; i < int'(pay_len); i++)
            begin
                ch = 8'($urandom);
                for (j = 7; j >= 0; j--)
                    bits.push_back(ch[j]);
            end
        end
        for (i = 0; i < bits.size() && (cut < 0 || i < cut); i++)
            send_file_byte(bits[i]);
        // trailing bytes land on a finished, halted or broken parse
        repeat ($urandom_range(0, 3)) send_file_byte(1'($urandom));
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic random_frame();
        logic [15:0] mg;
        logic [31:0] ext_w;
        logic [31:0] pay_w;
        int          pick;
        int          cut;
        if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
        mg = cur_magic;
        if ($urandom_range(0, 99) < 8)
            mg = cur_magic ^ 16'($urandom_range(1, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            ext_w = $urandom_range(EXT_BOUND + 1, 255);
        else if (pick < 10)
            ext_w = $urandom & 32'h7fff_ffff;
        else if (pick < 18)
            ext_w = 32'h8000_0000 | $urandom;
        else
            ext_w = $urandom_range(0, EXT_BOUND);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            pay_w = 32'h8000_0000 | $urandom;
        else if (pick < 14)
            pay_w = $urandom_range(PAYLOAD_CAP + 1, 32'h7fff_ffff);
        else
            pay_w = $urandom_range(0, 24);
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 120) : -1;
        send_frame(1'b1, cur_skip, mg, ext_w, pay_w, cut);
    endtask

    initial
    begin
        logic [15:0] m;
        int          ph;
        int          mark;

        in_ch.valid         = 1'b0;
        in_ch.pixel_byte    = '0;
        in_ch.start_of_file = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = lsd_pkg::REG_MAGIC_CODE;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames, zero header skip so the first byte carries a bit
        set_idle(IDLE_NONE);
        m = 16'ha5c3;
        set_config(m, 8'd0);
        // wrong magic, bytes after the halt give nothing
        send_frame(1'b1, 0, m ^ 16'h8001, 3, 2, -1);
        // extension one above the bound
        send_frame(1'b1, 0, m, EXT_BOUND + 1, 2, -1);
        // all-ones extension length counts as zero, single payload byte
        send_frame(1'b1, 0, m, 32'hffff_ffff, 1, -1);
        // extension right at the bound
        send_frame(1'b1, 0, m, EXT_BOUND, 2, -1);
        // zero extension and zero payload: frame ends with no item
        send_frame(1'b1, 0, m, 0, 0, -1);
        // both lengths with the top bit set
        send_frame(1'b1, 0, m, 32'h8000_0009, 32'h8000_0001, -1);
        // restart in the middle of the extension chars
        send_frame(1'b1, 0, m, 5, 4, 16 + 32 + 20);
        // largest positive payload length, cut off by the next file
        send_frame(1'b1, 0, m, 1, 32'h7fff_ffff, -1);

        // header skip lowered mid-file below the bytes already skipped
        drain();
        set_skip(8'd10);
        next_sof = 1'b1;
        repeat (3) send_file_byte(1'($urandom));
        drain();
        set_skip(8'd2);
        send_frame(1'b0, 0, m, 2, 3, -1);
        // header skip raised mid-file, three more bytes to skip
        drain();
        set_skip(8'd10);
        next_sof = 1'b1;
        repeat (3) send_file_byte(1'($urandom));
        drain();
        set_skip(8'd6);
        send_frame(1'b0, 3, m, 0, 2, -1);

        // random phases over register settings and idle patterns
        for (ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0:       set_config(16'hffff, 8'd0);
                1:       set_config(16'h0000, 8'd255);
                2:       set_config(16'($urandom), lsd_pkg::HEADER_SKIP_RESET);
                3:       set_config(16'($urandom), 8'd1);
                default: set_config(16'($urandom), 8'($urandom_range(0, 6)));
            endcase
            set_idle(idle_mode_t'(ph % 4));
            // receiver holds off while the sender keeps pushing at full rate until the queue is full
            if (ph == 4)
                hold_req = HOLD_CYCLES;
            mark = sent_bytes;
            while (sent_bytes - mark < PHASE_BYTES)
                random_frame();
        end

        drain();
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
